### src/mad_pkg.sv
// ----------------------------------------------------------------------------
// mad_pkg
// Shared widths, types, codes and helpers of the motion anomaly detector.
// ----------------------------------------------------------------------------
package mad_pkg;

  // Input delta width and run counter width
  localparam int DELTA_BITS = 16;
  localparam int RUN_BITS   = 8;

  // Fixed field widths
  localparam int STAMP_W    = 32;
  localparam int SPEED_W    = 16;
  localparam int MOVE_W     = 15;
  localparam int LIMIT_W    = 8;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  // Squared length, move compare and run compare widths
  localparam int SQ_W    = 2 * DELTA_BITS;
  localparam int ABS_W   = DELTA_BITS + 1;
  localparam int MVCMP_W = (ABS_W > MOVE_W) ? ABS_W : MOVE_W;
  localparam int RCMP_W  = (RUN_BITS > LIMIT_W) ? RUN_BITS : LIMIT_W;

  // Speed check: (dx^2+dy^2) * 10^6 against (speed_limit * dt)^2
  localparam int SCALE   = 1000000;
  localparam int SCALE_W = 20;
  localparam int LHS_W   = SQ_W + SCALE_W;
  localparam int LIM_W   = SPEED_W + STAMP_W;
  localparam int HALF_W  = LIM_W / 2;
  localparam int RHS_W   = 2 * LIM_W;

  // Shared multiplier operand: signed, wide enough for d2, dt and half of lim
  localparam int OPW    = (SQ_W > STAMP_W) ? SQ_W : STAMP_W;
  localparam int MUL_W  = OPW + 1;
  localparam int PROD_W = 2 * MUL_W;

  typedef logic signed [DELTA_BITS-1:0] delta_t;
  typedef logic        [STAMP_W-1:0]    stamp_t;
  typedef logic        [RUN_BITS-1:0]   run_t;
  typedef logic        [SQ_W-1:0]       sq_t;
  typedef logic        [LIM_W-1:0]      lim_t;
  typedef logic        [HALF_W-1:0]     half_t;
  typedef logic        [LHS_W-1:0]      lhs_t;
  typedef logic        [RHS_W-1:0]      rhs_t;
  typedef logic signed [MUL_W-1:0]      mul_t;
  typedef logic signed [PROD_W-1:0]     prod_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DETECT_ENABLE    = 3'd0,
    CFG_SPEED_LIMIT      = 3'd1,
    CFG_MIN_MOVE         = 3'd2,
    CFG_CONSISTENT_LIMIT = 3'd3,
    CFG_LINEAR_LIMIT     = 3'd4
  } cfg_idx_t;

  // Register reset values
  localparam logic [SPEED_W-1:0] SPEED_LIMIT_RST      = 16'd6000;
  localparam logic [MOVE_W-1:0]  MIN_MOVE_RST         = 15'd20;
  localparam logic [LIMIT_W-1:0] CONSISTENT_LIMIT_RST = 8'd10;
  localparam logic [LIMIT_W-1:0] LINEAR_LIMIT_RST     = 8'd20;

  typedef struct packed {
    logic               detect_enable;
    logic [SPEED_W-1:0] speed_limit;
    logic [MOVE_W-1:0]  min_move;
    logic [LIMIT_W-1:0] consistent_limit;
    logic [LIMIT_W-1:0] linear_limit;
  } cfg_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  // Multiplier steps, one product each up to STEP_LL, then drain and decide
  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;
  localparam step_t STEP_XX     = 4'd0;
  localparam step_t STEP_YY     = 4'd1;
  localparam step_t STEP_LXX    = 4'd2;
  localparam step_t STEP_LYY    = 4'd3;
  localparam step_t STEP_CROSSA = 4'd4;
  localparam step_t STEP_CROSSB = 4'd5;
  localparam step_t STEP_LIM    = 4'd6;
  localparam step_t STEP_LHS    = 4'd7;
  localparam step_t STEP_HH     = 4'd8;
  localparam step_t STEP_HL     = 4'd9;
  localparam step_t STEP_LL     = 4'd10;
  localparam step_t STEP_DRAIN  = 4'd11;
  localparam step_t STEP_DECIDE = 4'd12;

  function automatic mul_t sx_op(delta_t v);
    return mul_t'(v);
  endfunction

  function automatic mul_t zx_op(logic [OPW-1:0] v);
    return $signed({1'b0, v});
  endfunction

endpackage

### src/mad_if.sv
// ----------------------------------------------------------------------------
// mad_in_if / mad_out_if
// Valid/ready channels for motion reports and detection results.
// ----------------------------------------------------------------------------
interface mad_in_if;
  import mad_pkg::*;

  logic   valid;
  logic   ready;
  delta_t delta_x;
  delta_t delta_y;
  stamp_t stamp_ms;

  modport source (output valid, output delta_x, output delta_y, output stamp_ms,
                  input ready);
  modport sink   (input valid, input delta_x, input delta_y, input stamp_ms,
                  output ready);
endinterface

interface mad_out_if;
  logic valid;
  logic ready;
  logic checked;
  logic speed_alert;
  logic steady_alert;
  logic straight_alert;
  logic any_alert;

  modport source (output valid, output checked, output speed_alert,
                  output steady_alert, output straight_alert, output any_alert,
                  input ready);
  modport sink   (input valid, input checked, input speed_alert,
                  input steady_alert, input straight_alert, input any_alert,
                  output ready);
endinterface

### src/mad_cfg.sv
// ----------------------------------------------------------------------------
// mad_cfg
// Configuration register file, written by index, no read-back.
// ----------------------------------------------------------------------------
module mad_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             write_enable,
  input  logic [mad_pkg::CFG_IDX_W-1:0]    reg_index,
  input  logic [mad_pkg::CFG_DATA_W-1:0]   write_data,
  output mad_pkg::cfg_t                    cfg
);
  import mad_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.detect_enable    <= 1'b1;
      cfg.speed_limit      <= SPEED_LIMIT_RST;
      cfg.min_move         <= MIN_MOVE_RST;
      cfg.consistent_limit <= CONSISTENT_LIMIT_RST;
      cfg.linear_limit     <= LINEAR_LIMIT_RST;
    end else if (write_enable) begin
      unique case (reg_index)
        CFG_DETECT_ENABLE:    cfg.detect_enable    <= write_data[0];
        CFG_SPEED_LIMIT:      cfg.speed_limit      <= write_data[SPEED_W-1:0];
        CFG_MIN_MOVE:         cfg.min_move         <= write_data[MOVE_W-1:0];
        CFG_CONSISTENT_LIMIT: cfg.consistent_limit <= write_data[LIMIT_W-1:0];
        CFG_LINEAR_LIMIT:     cfg.linear_limit     <= write_data[LIMIT_W-1:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

endmodule

### src/mad_mul.sv
// ----------------------------------------------------------------------------
// mad_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module mad_mul (
  input  logic          clk,
  input  logic          en,
  input  mad_pkg::mul_t a,
  input  mad_pkg::mul_t b,
  output mad_pkg::prod_t prod
);
  import mad_pkg::*;

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= prod_t'(a) * prod_t'(b);
    end
  end

endmodule

### src/motion_anomaly_detector_unit.sv
// ----------------------------------------------------------------------------
// motion_anomaly_detector_unit
// Pointer motion anomaly detector: speed, equal-magnitude and straight-line runs.
// ----------------------------------------------------------------------------
// Usage:
//   sample : valid/ready sink of motion reports (delta_x, delta_y, stamp_ms).
//   result : valid/ready source, exactly one result item per report.
//   write_enable/reg_index/write_data : register writes, only while idle.
// Sequence:
//   A report that runs the checks takes 11 products through the one shared
//   multiplier (squares, cross products, limit times elapsed time, squared
//   length times 10^6, and the 96-bit square of limit times elapsed time
//   split into three 24-bit partial products), then a drain step and a
//   decide step, after which the done state loads the result register. A
//   report that skips the checks goes from idle straight to the done state.
//   sample.ready is high only while the sequencer is idle, so one report is
//   processed at a time.
// Stall:
//   The result sits in an output register; a new report is taken while it
//   waits, and the sequencer holds its finished result until that register
//   frees up.
// Reset:
//   Synchronous, active high. Registers return to their defaults, the stored
//   previous report and both run counters clear, no result is pending.
// ----------------------------------------------------------------------------
module motion_anomaly_detector_unit (
  input  logic                           clk,
  input  logic                           rst,
  mad_in_if.sink                         sample,
  mad_out_if.source                      result,
  input  logic                           write_enable,
  input  logic [mad_pkg::CFG_IDX_W-1:0]  reg_index,
  input  logic [mad_pkg::CFG_DATA_W-1:0] write_data
);
  import mad_pkg::*;

  cfg_t   cfg;
  state_t state;
  step_t  step;
  step_t  post_step;
  logic   post_en;

  // current report
  delta_t cur_dx;
  delta_t cur_dy;
  stamp_t cur_stamp;

  // stored state
  logic   have_last;
  delta_t last_dx;
  delta_t last_dy;
  stamp_t last_stamp;
  run_t   steady_run;
  run_t   straight_run;

  // work registers
  sq_t  d2;
  sq_t  p2;
  sq_t  cross_a;
  logic slope_eq;
  lim_t lim;
  lhs_t lhs;
  rhs_t rhs;

  // staged and output results
  logic res_chk, res_sp, res_st, res_sr;
  logic out_valid, out_chk, out_sp, out_st, out_sr;

  mul_t  mul_a, mul_b;
  prod_t prod;
  logic  mul_en;

  stamp_t dt;
  logic   accept;
  logic   big_move;
  logic   signed [ABS_W-1:0] in_dx_ext, in_dy_ext;
  logic   [ABS_W-1:0] in_ax, in_ay;
  logic   same_dir, same_slope, steady_hit, straight_hit;
  run_t   steady_next, straight_next;
  logic   speed_hit;

  mad_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data),
    .cfg          (cfg)
  );

  mad_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  function automatic run_t run_step(run_t run, logic hit);
    if (!hit) begin
      return '0;
    end
    return (run == '1) ? run : run + run_t'(1);
  endfunction

  function automatic logic opposite(delta_t a, delta_t b);
    logic a_pos, b_pos;
    a_pos = !a[DELTA_BITS-1] && (a != '0);
    b_pos = !b[DELTA_BITS-1] && (b != '0);
    return (a[DELTA_BITS-1] && b_pos) || (a_pos && b[DELTA_BITS-1]);
  endfunction

  assign accept       = sample.valid && sample.ready;
  assign sample.ready = (state == ST_IDLE);

  // move gate on the incoming report
  assign in_dx_ext = ABS_W'(sample.delta_x);
  assign in_dy_ext = ABS_W'(sample.delta_y);
  assign in_ax     = in_dx_ext[ABS_W-1] ? ABS_W'(-in_dx_ext) : ABS_W'(in_dx_ext);
  assign in_ay     = in_dy_ext[ABS_W-1] ? ABS_W'(-in_dy_ext) : ABS_W'(in_dy_ext);
  assign big_move  = (MVCMP_W'(in_ax) > MVCMP_W'(cfg.min_move)) ||
                     (MVCMP_W'(in_ay) > MVCMP_W'(cfg.min_move));

  assign dt = cur_stamp - last_stamp;

  // operand select for the shared multiplier
  always_comb begin
    mul_en = (state == ST_CALC) && (step <= STEP_LL);
    mul_a  = '0;
    mul_b  = '0;
    unique case (step)
      STEP_XX: begin
        mul_a = sx_op(cur_dx);
        mul_b = sx_op(cur_dx);
      end
      STEP_YY: begin
        mul_a = sx_op(cur_dy);
        mul_b = sx_op(cur_dy);
      end
      STEP_LXX: begin
        mul_a = sx_op(last_dx);
        mul_b = sx_op(last_dx);
      end
      STEP_LYY: begin
        mul_a = sx_op(last_dy);
        mul_b = sx_op(last_dy);
      end
      STEP_CROSSA: begin
        mul_a = sx_op(cur_dy);
        mul_b = sx_op(last_dx);
      end
      STEP_CROSSB: begin
        mul_a = sx_op(last_dy);
        mul_b = sx_op(cur_dx);
      end
      STEP_LIM: begin
        mul_a = zx_op(OPW'(cfg.speed_limit));
        mul_b = zx_op(OPW'(dt));
      end
      STEP_LHS: begin
        mul_a = zx_op(OPW'(d2));
        mul_b = zx_op(OPW'(SCALE));
      end
      STEP_HH: begin
        mul_a = zx_op(OPW'(lim[LIM_W-1:HALF_W]));
        mul_b = zx_op(OPW'(lim[LIM_W-1:HALF_W]));
      end
      STEP_HL: begin
        mul_a = zx_op(OPW'(lim[LIM_W-1:HALF_W]));
        mul_b = zx_op(OPW'(lim[HALF_W-1:0]));
      end
      STEP_LL: begin
        mul_a = zx_op(OPW'(lim[HALF_W-1:0]));
        mul_b = zx_op(OPW'(lim[HALF_W-1:0]));
      end
      default: ;
    endcase
  end

  // decision logic, used in the decide step
  always_comb begin
    same_dir = !opposite(cur_dx, last_dx) && !opposite(cur_dy, last_dy);
    // vertical pairs count as the same slope; one vertical never does
    if (cur_dx == '0 || last_dx == '0) begin
      same_slope = (cur_dx == '0) && (last_dx == '0);
    end else begin
      same_slope = slope_eq;
    end
    steady_hit    = (d2 == p2);
    straight_hit  = same_dir && same_slope;
    steady_next   = run_step(steady_run, steady_hit);
    straight_next = run_step(straight_run, straight_hit);
    speed_hit     = (dt != '0) && (rhs_t'(lhs) > rhs);
  end

  // product post-processing, driven by a registered copy of the step
  always_ff @(posedge clk) begin
    if (post_en) begin
      unique case (post_step)
        STEP_XX:     d2       <= prod[SQ_W-1:0];
        STEP_YY:     d2       <= d2 + prod[SQ_W-1:0];
        STEP_LXX:    p2       <= prod[SQ_W-1:0];
        STEP_LYY:    p2       <= p2 + prod[SQ_W-1:0];
        STEP_CROSSA: cross_a  <= prod[SQ_W-1:0];
        STEP_CROSSB: slope_eq <= (cross_a == prod[SQ_W-1:0]);
        STEP_LIM:    lim      <= prod[LIM_W-1:0];
        STEP_LHS:    lhs      <= prod[LHS_W-1:0];
        STEP_HH:     rhs      <= rhs_t'(prod[2*HALF_W-1:0]) << (2 * HALF_W);
        STEP_HL:     rhs      <= rhs + (rhs_t'(prod[2*HALF_W-1:0]) << (HALF_W + 1));
        STEP_LL:     rhs      <= rhs + rhs_t'(prod[2*HALF_W-1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_dx    <= sample.delta_x;
      cur_dy    <= sample.delta_y;
      cur_stamp <= sample.stamp_ms;
    end
  end

  // sequencer, stored report and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      step         <= STEP_XX;
      post_step    <= STEP_XX;
      post_en      <= 1'b0;
      have_last    <= 1'b0;
      last_dx      <= '0;
      last_dy      <= '0;
      last_stamp   <= '0;
      steady_run   <= '0;
      straight_run <= '0;
      res_chk      <= 1'b0;
      res_sp       <= 1'b0;
      res_st       <= 1'b0;
      res_sr       <= 1'b0;
      out_valid    <= 1'b0;
      out_chk      <= 1'b0;
      out_sp       <= 1'b0;
      out_st       <= 1'b0;
      out_sr       <= 1'b0;
    end else begin
      post_en   <= mul_en;
      post_step <= step;
      // in the done state the output register is reloaded instead
      if (out_valid && result.ready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            res_chk <= 1'b0;
            res_sp  <= 1'b0;
            res_st  <= 1'b0;
            res_sr  <= 1'b0;
            if (!cfg.detect_enable) begin
              state <= ST_DONE;
            end else if (have_last && big_move) begin
              step  <= STEP_XX;
              state <= ST_CALC;
            end else begin
              have_last  <= 1'b1;
              last_dx    <= sample.delta_x;
              last_dy    <= sample.delta_y;
              last_stamp <= sample.stamp_ms;
              state      <= ST_DONE;
            end
          end
        end
        ST_CALC: begin
          if (step == STEP_DECIDE) begin
            steady_run   <= steady_next;
            straight_run <= straight_next;
            res_chk      <= 1'b1;
            res_sp       <= speed_hit;
            res_st       <= RCMP_W'(steady_next) >= RCMP_W'(cfg.consistent_limit);
            res_sr       <= RCMP_W'(straight_next) >= RCMP_W'(cfg.linear_limit);
            last_dx      <= cur_dx;
            last_dy      <= cur_dy;
            last_stamp   <= cur_stamp;
            state        <= ST_DONE;
          end else begin
            step <= step + step_t'(1);
          end
        end
        ST_DONE: begin
          if (!out_valid || result.ready) begin
            out_valid <= 1'b1;
            out_chk   <= res_chk;
            out_sp    <= res_sp;
            out_st    <= res_st;
            out_sr    <= res_sr;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign result.valid          = out_valid;
  assign result.checked        = out_chk;
  assign result.speed_alert    = out_sp;
  assign result.steady_alert   = out_st;
  assign result.straight_alert = out_sr;
  assign result.any_alert      = out_sp | out_st | out_sr;

  // assertions
  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("sequencer state not one-hot");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CALC) |-> (step <= STEP_DECIDE))
    else $error("step counter ran past decide");

  a_have_last_set: assert property (@(posedge clk) disable iff (rst)
    $rose(have_last) |-> $past(accept))
    else $error("previous report marked without an accepted item");

  a_alert_needs_check: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.checked) |-> !result.any_alert)
    else $error("alert raised on an unchecked item");

  a_calc_needs_last: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CALC) |-> have_last)
    else $error("checks running without a previous report");

endmodule

### dv/tb_motion_anomaly_detector_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_motion_anomaly_detector_unit
// Self-checking bench for the motion anomaly detector. Motion reports are
// queued by the stimulus process and sent by a clocked driver with random
// gaps. A clocked monitor scores every accepted report against a local
// model of the speed, equal-magnitude and straight-line checks, then matches
// each result item against the oldest expected verdict. Register settings
// change only while the block is drained.
// ----------------------------------------------------------------------------
module tb_motion_anomaly_detector_unit;
  import mad_pkg::*;

  localparam int     CLK_HALF_NS    = 4;
  localparam int     RESET_CYCLES   = 6;
  localparam int     TIMEOUT_NS     = 6_000_000;
  localparam int     END_WAIT       = 40;
  localparam int     MAX_WAIT       = 9;
  localparam longint MS_PER_S_SQ    = 1000000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

  typedef struct {
    delta_t dx;
    delta_t dy;
    stamp_t stamp;
  } report_t;

  typedef struct packed {
    logic checked;
    logic speed;
    logic steady;
    logic straight;
    logic any_hit;
  } verdict_t;

  logic clk = 1'b0;
  logic rst;
  logic                  write_enable;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] write_data;

  mad_in_if  sample_if ();
  mad_out_if result_if ();

  motion_anomaly_detector_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .sample       (sample_if),
    .result       (result_if),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data)
  );

  // Local copy of registers and detector state
  logic               en_cfg;
  logic [SPEED_W-1:0] speed_cfg;
  logic [MOVE_W-1:0]  move_cfg;
  logic [LIMIT_W-1:0] steady_cfg;
  logic [LIMIT_W-1:0] straight_cfg;
  logic               have_prev    = 1'b0;
  delta_t             prev_dx      = '0;
  delta_t             prev_dy      = '0;
  stamp_t             prev_stamp   = '0;
  run_t               steady_cnt   = '0;
  run_t               straight_cnt = '0;

  report_t  report_q[$];
  verdict_t verdict_q[$];
  int       err_cnt = 0;
  int       queued_cnt = 0;
  stamp_t   gen_stamp = '0;

  logic in_taken  = 1'b0;
  logic out_taken = 1'b0;
  int   send_gap = 0, send_burst = 0;
  int   recv_wait = 0, recv_burst = 0;

  initial begin
    forever #(CLK_HALF_NS) clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("TB_ERROR");
    $finish;
  end

  function automatic run_t bump_run(run_t cnt, logic hit);
    if (!hit) return '0;
    return (cnt == {RUN_BITS{1'b1}}) ? cnt : cnt + run_t'(1);
  endfunction

  function automatic verdict_t score_report(report_t r);
    verdict_t     v;
    longint       cx, cy, px, py, ax, ay, d2, p2;
    stamp_t       dt;
    logic [127:0] lim, lhs, rhs;
    logic         same_dir, same_slope;
    v = '0;
    if (!en_cfg) return v;
    cx = r.dx;
    cy = r.dy;
    px = prev_dx;
    py = prev_dy;
    ax = (cx < 0) ? -cx : cx;
    ay = (cy < 0) ? -cy : cy;
    if (have_prev && (ax > longint'(move_cfg) || ay > longint'(move_cfg))) begin
      v.checked = 1'b1;
      d2 = cx * cx + cy * cy;
      p2 = px * px + py * py;
      dt = r.stamp - prev_stamp;
      // speed check skipped when no time has passed
      if (dt != '0) begin
        lim = 128'(speed_cfg) * 128'(dt);
        lhs = 128'(d2) * 128'(MS_PER_S_SQ);
        rhs = lim * lim;
        v.speed = (lhs > rhs);
      end
      steady_cnt = bump_run(steady_cnt, d2 == p2);
      v.steady = (steady_cnt >= steady_cfg);
      same_dir = (cx * px >= 0) && (cy * py >= 0);
      // vertical pairs count as equal slope, one vertical does not
      if (cx == 0 || px == 0) same_slope = (cx == 0) && (px == 0);
      else same_slope = (cy * px == py * cx);
      straight_cnt = bump_run(straight_cnt, same_dir && same_slope);
      v.straight = (straight_cnt >= straight_cfg);
    end
    v.any_hit = v.speed | v.steady | v.straight;
    have_prev  = 1'b1;
    prev_dx    = r.dx;
    prev_dy    = r.dy;
    prev_stamp = r.stamp;
    return v;
  endfunction

  task automatic check_bit(string name, logic want, logic got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0b actual %0b", $time, name, want, got);
      err_cnt++;
    end
  endtask

  // Report driver
  always @(negedge clk) begin : drive_reports
    report_t rep;
    if (rst) begin
      sample_if.valid    <= 1'b0;
      sample_if.delta_x  <= '0;
      sample_if.delta_y  <= '0;
      sample_if.stamp_ms <= '0;
      send_gap <= 0;
    end else if (!sample_if.valid || in_taken) begin
      if (send_gap > 0) begin
        sample_if.valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (report_q.size() > 0) begin
        rep = report_q[0];
        report_q.delete(0);
        sample_if.valid    <= 1'b1;
        sample_if.delta_x  <= rep.dx;
        sample_if.delta_y  <= rep.dy;
        sample_if.stamp_ms <= rep.stamp;
        if (send_burst > 0) begin
          send_burst <= send_burst - 1;
          send_gap <= 0;
        end else begin
          send_gap <= $urandom_range(0, MAX_WAIT);
          if ($urandom_range(0, 19) == 0) send_burst <= $urandom_range(10, 60);
        end
      end else begin
        sample_if.valid <= 1'b0;
      end
    end
  end

  // Result sink with per-item stall
  always @(negedge clk) begin : drive_ready
    int w;
    if (rst) begin
      result_if.ready <= 1'b0;
      recv_wait <= 0;
    end else if (out_taken) begin
      if (recv_burst > 0) begin
        recv_burst <= recv_burst - 1;
        w = 0;
      end else begin
        w = $urandom_range(0, MAX_WAIT);
        if ($urandom_range(0, 19) == 0) recv_burst <= $urandom_range(10, 60);
      end
      recv_wait <= w;
      result_if.ready <= (w == 0);
    end else if (recv_wait > 0) begin
      recv_wait <= recv_wait - 1;
      result_if.ready <= (recv_wait == 1);
    end else begin
      result_if.ready <= 1'b1;
    end
  end

  // Monitor: score accepted reports, match result items
  always @(posedge clk) begin : watch
    verdict_t got, want;
    report_t  rep;
    if (rst) begin
      in_taken  <= 1'b0;
      out_taken <= 1'b0;
    end else begin
      in_taken  <= sample_if.valid && sample_if.ready;
      out_taken <= result_if.valid && result_if.ready;
      // results first: a result never belongs to a report taken on this edge
      if (result_if.valid && result_if.ready) begin
        got = {result_if.checked, result_if.speed_alert, result_if.steady_alert,
               result_if.straight_alert, result_if.any_alert};
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %b", $time, got);
          err_cnt++;
        end else begin
          want = verdict_q[0];
          verdict_q.delete(0);
          check_bit("checked", want.checked, got.checked);
          check_bit("speed_alert", want.speed, got.speed);
          check_bit("steady_alert", want.steady, got.steady);
          check_bit("straight_alert", want.straight, got.straight);
          check_bit("any_alert", want.any_hit, got.any_hit);
        end
      end
      if (sample_if.valid && sample_if.ready) begin
        rep.dx    = sample_if.delta_x;
        rep.dy    = sample_if.delta_y;
        rep.stamp = sample_if.stamp_ms;
        verdict_q.insert(verdict_q.size(), score_report(rep));
      end
    end
  end

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int unsigned data);
    @(negedge clk);
    write_enable = 1'b1;
    reg_index    = idx;
    write_data   = CFG_DATA_W'(data);
    case (idx)
      CFG_DETECT_ENABLE:    en_cfg       = data[0];
      CFG_SPEED_LIMIT:      speed_cfg    = data[SPEED_W-1:0];
      CFG_MIN_MOVE:         move_cfg     = data[MOVE_W-1:0];
      CFG_CONSISTENT_LIMIT: steady_cfg   = data[LIMIT_W-1:0];
      CFG_LINEAR_LIMIT:     straight_cfg = data[LIMIT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    write_enable = 1'b0;
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (report_q.size() != 0 || sample_if.valid || verdict_q.size() != 0)
      @(posedge clk);
  endtask

  task automatic push_at(int dx, int dy, stamp_t st);
    report_t r;
    r.dx    = delta_t'(dx);
    r.dy    = delta_t'(dy);
    r.stamp = st;
    gen_stamp = st;
    report_q.insert(report_q.size(), r);
    queued_cnt++;
  endtask

  function automatic stamp_t next_stamp();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) return gen_stamp;
    if (pick < 60) return gen_stamp + $urandom_range(1, 16);
    if (pick < 85) return gen_stamp + $urandom_range(17, 200);
    if (pick < 95) return gen_stamp + $urandom();
    return gen_stamp + $urandom_range(1000, 100000);
  endfunction

  task automatic add_segment();
    int mode, len, ux, uy, k, kmax, big, a, b, s, m, i;
    mode = $urandom_range(0, 9);
    case (mode)
      0, 1: begin  // noise, full range
        len = $urandom_range(1, 6);
        for (i = 0; i < len; i++) push_at($urandom(), $urandom(), next_stamp());
      end
      2, 3: begin  // straight line, mostly same direction, varying length
        ux = int'($urandom_range(0, 40)) - 20;
        uy = int'($urandom_range(0, 40)) - 20;
        if ($urandom_range(0, 4) == 0) ux = 0;
        if (ux == 0 && uy == 0) uy = 7;
        big = (ux < 0 ? -ux : ux) > (uy < 0 ? -uy : uy) ? (ux < 0 ? -ux : ux)
                                                       : (uy < 0 ? -uy : uy);
        kmax = 32767 / big;
        if (kmax > 400 && $urandom_range(0, 7) != 0) kmax = 400;
        len = $urandom_range(4, 40);
        for (i = 0; i < len; i++) begin
          k = $urandom_range(1, kmax);
          if ($urandom_range(0, 11) == 0) k = -k;
          push_at(k * ux, k * uy, next_stamp());
        end
      end
      4, 5: begin  // equal magnitude, signs and axes permuted
        m = ($urandom_range(0, 7) == 0) ? 32767 : 2000;
        a = $urandom_range(0, m);
        b = $urandom_range(0, m);
        len = $urandom_range(4, 40);
        for (i = 0; i < len; i++) begin
          s = $urandom_range(0, 7);
          if (s[2]) push_at(s[0] ? -b : b, s[1] ? -a : a, next_stamp());
          else push_at(s[0] ? -a : a, s[1] ? -b : b, next_stamp());
        end
      end
      6: begin  // identical repeats
        a = int'($urandom_range(0, 600)) - 300;
        b = int'($urandom_range(0, 600)) - 300;
        len = $urandom_range(4, 30);
        for (i = 0; i < len; i++) push_at(a, b, next_stamp());
      end
      7: begin  // at or below the movement threshold
        m = move_cfg;
        len = $urandom_range(1, 5);
        for (i = 0; i < len; i++)
          push_at(int'($urandom_range(0, 2 * m)) - m, int'($urandom_range(0, 2 * m)) - m,
                  next_stamp());
      end
      default: begin  // moderate random motion
        len = $urandom_range(3, 15);
        for (i = 0; i < len; i++)
          push_at(int'($urandom_range(0, 600)) - 300, int'($urandom_range(0, 600)) - 300,
                  next_stamp());
      end
    endcase
  endtask

  task automatic run_random(int n);
    int target;
    target = queued_cnt + n;
    while (queued_cnt < target) add_segment();
  endtask

  task automatic random_config();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 2) cfg_write(CFG_SPEED_LIMIT, $urandom_range(0, 100));
    else if (pick < 7) cfg_write(CFG_SPEED_LIMIT, $urandom_range(1000, 20000));
    else if (pick < 8) cfg_write(CFG_SPEED_LIMIT, 32'h0000_FFFF);
    else cfg_write(CFG_SPEED_LIMIT, $urandom());
    pick = $urandom_range(0, 19);
    if (pick < 14) cfg_write(CFG_MIN_MOVE, $urandom_range(0, 60));
    else if (pick < 17) cfg_write(CFG_MIN_MOVE, $urandom_range(0, 500));
    else cfg_write(CFG_MIN_MOVE, $urandom());
    pick = $urandom_range(0, 4);
    cfg_write(CFG_CONSISTENT_LIMIT, pick < 3 ? $urandom_range(0, 12) :
                                    pick < 4 ? $urandom_range(13, 40) : $urandom());
    pick = $urandom_range(0, 4);
    cfg_write(CFG_LINEAR_LIMIT, pick < 3 ? $urandom_range(0, 12) :
                                pick < 4 ? $urandom_range(13, 40) : $urandom());
  endtask

  initial begin : stimulus
    int i;
    rst = 1'b1;
    write_enable = 1'b0;
    reg_index    = CFG_DETECT_ENABLE;
    write_data   = '0;
    en_cfg       = 1'b1;
    speed_cfg    = SPEED_LIMIT_RST;
    move_cfg     = MIN_MOVE_RST;
    steady_cfg   = CONSISTENT_LIMIT_RST;
    straight_cfg = LINEAR_LIMIT_RST;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed, reset register values
    push_at(100, 0, 32'd1000);          // nothing stored yet
    push_at(-32768, -32768, 32'd1001);  // most negative, far too fast
    push_at(32767, 32767, 32'd1001);    // no elapsed time, opposite direction
    push_at(20, -20, 32'd1005);         // exactly the threshold: not checked
    push_at(21, 0, 32'd1010);
    push_at(-21, 0, 32'd1020);
    push_at(0, 50, 32'd1030);           // vertical pair
    push_at(0, 80, 32'd1040);
    push_at(0, -80, 32'd1050);          // vertical, reversed
    push_at(50, 50, 32'd1060);          // only previous is vertical
    push_at(-50, -50, 32'd1070);
    push_at(30, 40, 32'hFFFF_FFF0);
    push_at(40, 30, 32'h0000_0010);     // stamp wraps, equal magnitude
    push_at(50, 0, 32'd40);
    push_at(0, -50, 32'd50);
    push_at(60, 0, 32'd2000);
    push_at(0, 60, 32'd2010);           // speed exactly at the limit
    push_at(0, 61, 32'd2020);           // just over
    push_at(0, -32768, 32'd2021);
    push_at(0, 32767, 32'd2022);
    push_at(-32768, 0, 32'd2023);
    push_at(32767, -32768, 32'd2024);
    gen_stamp = 32'd3000;
    wait_drained();

    // Detection off: reports ignored, state kept
    cfg_write(CFG_DETECT_ENABLE, 32'h0000_FFFE);
    for (i = 0; i < 15; i++) push_at($urandom(), $urandom(), next_stamp());
    wait_drained();
    cfg_write(CFG_UNUSED_IDX, $urandom());
    cfg_write(CFG_DETECT_ENABLE, 32'h0000_0001);
    run_random(20);
    wait_drained();

    // All limits at zero
    cfg_write(CFG_SPEED_LIMIT, 32'h0000_0000);
    cfg_write(CFG_MIN_MOVE, 32'h0000_0000);
    cfg_write(CFG_CONSISTENT_LIMIT, 32'h0000_0000);
    cfg_write(CFG_LINEAR_LIMIT, 32'h0000_0000);
    run_random(150);
    wait_drained();

    // All limits at their top
    cfg_write(CFG_SPEED_LIMIT, 32'h0000_FFFF);
    cfg_write(CFG_MIN_MOVE, 32'h0000_FFFF);
    cfg_write(CFG_CONSISTENT_LIMIT, 32'h0000_FFFF);
    cfg_write(CFG_LINEAR_LIMIT, 32'h0000_00FF);
    run_random(120);
    wait_drained();

    // Long identical run drives both counters into saturation
    cfg_write(CFG_MIN_MOVE, 32'd20);
    cfg_write(CFG_SPEED_LIMIT, $urandom_range(1000, 20000));
    for (i = 0; i < 300; i++) push_at(37, -12, gen_stamp + $urandom_range(1, 10));
    wait_drained();

    for (i = 0; i < 6; i++) begin
      random_config();
      run_random(230);
      wait_drained();
    end

    repeat (END_WAIT) @(posedge clk);
    if (err_cnt == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
